FILE: rtl/dtw_pkg.sv
// ---------------------------------------------------------------------------
// dtw_pkg
// shared types and codes of the sequence walker: classified items, results,
// walker phases, result kinds and error codes
// ---------------------------------------------------------------------------
`default_nettype none

package dtw_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TAG  = 3'd1,
    PH_LEN0 = 3'd2,
    PH_LENX = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_FORM  = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  localparam logic [7:0] LONG_FORM_BIT = 8'h80;
  localparam logic [6:0] COUNT_MASK    = 7'h7F;
  localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

  // classified item as it travels from front to back
  typedef struct packed {
    logic        is_start;
    logic [31:0] region_length;
    logic [7:0]  data_byte;
    logic        long_form;
    logic        cnt_zero;
    logic        cnt_over;
    logic [2:0]  cnt;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [31:0] length;
    logic [2:0]  hdr_bytes;
    logic [31:0] offset;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/der_tlv_sequence_walker_unit.sv
// ---------------------------------------------------------------------------
// der_tlv_sequence_walker_unit
// walks the children of a DER SEQUENCE one byte per item, reporting each
// child's tag, length, header size and offset, then done or an error
//
//   channel  ports                                    direction
//   input    in_valid in_stall in_action              in
//            in_region_length in_data_byte
//   result   out_valid out_stall out_result_kind      out
//            out_elem_tag out_elem_length out_elem_header_len
//            out_elem_offset out_error_code out_last_result
//
// one item per cycle through the walker while the output register is free;
// a child header followed by done on the same byte holds the walker until
// the done result is sent; a taken item is held in a queue slot, then its
// result in the output reg
// in_stall rises only when the item queue is full
// synchronous reset empties the queue and leaves the walker idle
// ---------------------------------------------------------------------------
`default_nettype none

module der_tlv_sequence_walker_unit
  import dtw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_region_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_elem_tag,
  output logic [31:0]      out_elem_length,
  output logic [2:0]       out_elem_header_len,
  output logic [31:0]      out_elem_offset,
  output logic [1:0]       out_error_code,
  output logic             out_last_result
);

  item_t   cls_item, head_item;
  logic    q_full, q_not_empty, q_pop, q_push;
  result_t res;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  dtw_front u_front (
    .in_action        (in_action),
    .in_region_length (in_region_length),
    .in_data_byte     (in_data_byte),
    .item             (cls_item)
  );

  dtw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (cls_item),
    .pop       (q_pop),
    .head      (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  dtw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (head_item),
    .item_valid (q_not_empty),
    .item_pop   (q_pop),
    .out_res    (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  assign out_result_kind     = res.kind;
  assign out_elem_tag        = res.tag;
  assign out_elem_length     = res.length;
  assign out_elem_header_len = res.hdr_bytes;
  assign out_elem_offset     = res.offset;
  assign out_error_code      = res.error_code;
  assign out_last_result     = res.last;

endmodule

`default_nettype wire

FILE: rtl/dtw_front.sv
// ---------------------------------------------------------------------------
// dtw_front
// classifies an incoming item: start or data, and the length form fields of
// its byte, ready for the walker
// ---------------------------------------------------------------------------
`default_nettype none

module dtw_front
  import dtw_pkg::*;
(
  input  wire logic        in_action,
  input  wire logic [31:0] in_region_length,
  input  wire logic [7:0]  in_data_byte,
  output item_t            item
);

  logic [6:0] count;

  assign count = in_data_byte[6:0] & COUNT_MASK;

  always_comb begin
    item               = '0;
    item.is_start      = ~in_action;
    item.region_length = in_region_length;
    item.data_byte     = in_data_byte;
    item.long_form     = (in_data_byte & LONG_FORM_BIT) != 8'h00;
    item.cnt_zero      = count == 7'd0;
    item.cnt_over      = count > MAX_LEN_BYTES;
    item.cnt           = count[2:0];
  end

endmodule

`default_nettype wire

FILE: rtl/dtw_queue.sv
// ---------------------------------------------------------------------------
// dtw_queue
// short item queue between front and back, full flag from a registered count
// ---------------------------------------------------------------------------
`default_nettype none

module dtw_queue
  import dtw_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     push_item,
  input  wire logic pop,
  output item_t     head,
  output logic      not_empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  item_t         slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == FULL_CNT;
  assign head      = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_SLOT) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_SLOT) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtw_back.sv
// ---------------------------------------------------------------------------
// dtw_back
// walker state machine: takes classified items from the queue, tracks the
// region and child counters and fills the output register
// ---------------------------------------------------------------------------
`default_nettype none

module dtw_back
  import dtw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  item_t     item,
  input  wire logic item_valid,
  output logic      item_pop,
  output result_t   out_res,
  output logic      out_valid,
  input  wire logic out_stall
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [31:0] br_r, br_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] cs_r, cs_nxt;
  logic [31:0] vs_r, vs_nxt;

  logic        ov_r, ov_nxt;
  logic        pend_r, pend_nxt;
  result_t     res_r, res_nxt;

  logic        out_free;
  logic [31:0] br_dec, vs_dec, acc_shift, fin_len;
  logic [2:0]  left_dec, fin_hc;
  logic        do_fin;
  logic        r0v, r1v;
  result_t     r0, done_res;

  assign out_free  = !ov_r || !out_stall;
  assign item_pop  = item_valid && out_free && !pend_r;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  assign br_dec    = br_r - {31'd0, br_r != 32'd0};
  assign vs_dec    = vs_r - {31'd0, vs_r != 32'd0};
  assign left_dec  = left_r - {2'd0, left_r != 3'd0};
  assign acc_shift = {acc_r[23:0], item.data_byte};

  always_comb begin
    done_res      = '0;
    done_res.kind = KIND_DONE;
    done_res.last = 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    hc_nxt    = hc_r;
    br_nxt    = br_r;
    pos_nxt   = pos_r;
    cs_nxt    = cs_r;
    vs_nxt    = vs_r;
    r0v       = 1'b0;
    r1v       = 1'b0;
    r0        = '0;
    do_fin    = 1'b0;
    fin_len   = acc_shift;
    fin_hc    = hc_r + 3'd1;

    if (item_pop) begin
      if (item.is_start) begin
        tag_nxt  = '0;
        acc_nxt  = '0;
        left_nxt = '0;
        hc_nxt   = '0;
        pos_nxt  = '0;
        cs_nxt   = '0;
        vs_nxt   = '0;
        br_nxt   = item.region_length;
        if (item.region_length == 32'd0) begin
          r0v       = 1'b1;
          r0        = done_res;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_TAG;
        end
      end else begin
        unique case (phase_r)
          PH_TAG: begin
            cs_nxt   = pos_r;
            tag_nxt  = item.data_byte;
            hc_nxt   = 3'd1;
            acc_nxt  = '0;
            left_nxt = '0;
            br_nxt   = br_dec;
            pos_nxt  = pos_r + 32'd1;
            if (br_r < 32'd2) begin
              r0v           = 1'b1;
              r0.kind       = KIND_ERR;
              r0.offset     = pos_r;
              r0.error_code = ERR_SHORT;
              r0.last       = 1'b1;
              phase_nxt     = PH_IDLE;
            end else begin
              phase_nxt = PH_LEN0;
            end
          end
          PH_LEN0: begin
            br_nxt  = br_dec;
            pos_nxt = pos_r + 32'd1;
            hc_nxt  = 3'd2;
            if (!item.long_form) begin
              do_fin  = 1'b1;
              fin_len = {25'd0, item.data_byte[6:0]};
              fin_hc  = 3'd2;
            end else if (item.cnt_zero || item.cnt_over || {29'd0, item.cnt} > br_dec) begin
              r0v           = 1'b1;
              r0.kind       = KIND_ERR;
              r0.offset     = cs_r;
              r0.last       = 1'b1;
              phase_nxt     = PH_IDLE;
              if (item.cnt_zero) begin
                r0.error_code = ERR_FORM;
              end else if (item.cnt_over) begin
                r0.error_code = ERR_OVF;
              end else begin
                r0.error_code = ERR_SHORT;
              end
            end else begin
              acc_nxt   = '0;
              left_nxt  = item.cnt;
              phase_nxt = PH_LENX;
            end
          end
          PH_LENX: begin
            br_nxt   = br_dec;
            pos_nxt  = pos_r + 32'd1;
            acc_nxt  = acc_shift;
            hc_nxt   = hc_r + 3'd1;
            left_nxt = left_dec;
            if (left_dec == 3'd0) begin
              do_fin = 1'b1;
            end
          end
          PH_SKIP: begin
            br_nxt  = br_dec;
            pos_nxt = pos_r + 32'd1;
            vs_nxt  = vs_dec;
            if (vs_dec == 32'd0) begin
              if (br_dec == 32'd0) begin
                r0v       = 1'b1;
                r0        = done_res;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_TAG;
              end
            end
          end
          PH_IDLE: begin
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase

        // length complete: check against region, emit header or a short error
        if (do_fin) begin
          acc_nxt = fin_len;
          r0v     = 1'b1;
          if (fin_len > br_dec) begin
            r0.kind       = KIND_ERR;
            r0.offset     = cs_r;
            r0.error_code = ERR_SHORT;
            r0.last       = 1'b1;
            phase_nxt     = PH_IDLE;
          end else begin
            r0.kind       = KIND_HDR;
            r0.tag        = tag_r;
            r0.length     = fin_len;
            r0.hdr_bytes  = fin_hc;
            r0.offset     = cs_r;
            if (fin_len == 32'd0) begin
              if (br_dec == 32'd0) begin
                r1v       = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_TAG;
              end
            end else begin
              vs_nxt    = fin_len;
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
    end
  end

  // output register with a pending done slot for the second result
  always_comb begin
    ov_nxt   = ov_r;
    pend_nxt = pend_r;
    res_nxt  = res_r;
    if (out_free) begin
      if (pend_r) begin
        ov_nxt   = 1'b1;
        res_nxt  = done_res;
        pend_nxt = 1'b0;
      end else if (r0v) begin
        ov_nxt   = 1'b1;
        res_nxt  = r0;
        pend_nxt = r1v;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tag_r   <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      hc_r    <= '0;
      br_r    <= '0;
      pos_r   <= '0;
      cs_r    <= '0;
      vs_r    <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      hc_r    <= hc_nxt;
      br_r    <= br_nxt;
      pos_r   <= pos_nxt;
      cs_r    <= cs_nxt;
      vs_r    <= vs_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench for der_tlv_sequence_walker_unit
// a directed table, then random regions of mostly well-formed children with
// some noise and broken encodings; each child header, done and error result
// is predicted from the walker state and checked in order on the result side
// ---------------------------------------------------------------------------
module testbench;
  import dtw_pkg::*;

  localparam bit ACT_START   = 1'b0;
  localparam bit ACT_DATA    = 1'b1;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam result_t NO_RESULT   = '0;
  localparam result_t DONE_RESULT = '{KIND_DONE, 8'h00, 32'h0, 3'd0, 32'h0, ERR_NONE, 1'b1};

  typedef struct {
    bit          act;
    logic [31:0] rlen;
    logic [7:0]  dbyte;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [31:0] in_region_length = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_elem_tag;
  logic [31:0] out_elem_length;
  logic [2:0]  out_elem_header_len;
  logic [31:0] out_elem_offset;
  logic [1:0]  out_error_code;
  logic        out_last_result;

  int tx_idle_pct = 30;
  int rx_idle_pct = 85;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_taken = 0;

  result_t   walker_results_due[$];
  stim_row_t directed_rows[$];

  // walker state as predicted
  phase_t      walk_phase = PH_IDLE;
  logic [7:0]  tag_held = '0;
  logic [31:0] len_accum = '0;
  logic [2:0]  len_left = '0;
  logic [2:0]  hdr_count = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] pos = '0;
  logic [31:0] child_at = '0;
  logic [31:0] skip_left = '0;

  der_tlv_sequence_walker_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_region_length    (in_region_length),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_elem_tag        (out_elem_tag),
    .out_elem_length     (out_elem_length),
    .out_elem_header_len (out_elem_header_len),
    .out_elem_offset     (out_elem_offset),
    .out_error_code      (out_error_code),
    .out_last_result     (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic result_t error_at(logic [1:0] code, logic [31:0] off);
    return '{KIND_ERR, 8'h00, 32'h0, 3'd0, off, code, 1'b1};
  endfunction

  function void add_row(bit act, logic [31:0] rlen, logic [7:0] b, bit typed, result_t want);
    stim_row_t row;
    row.act = act;
    row.rlen = rlen;
    row.dbyte = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function void post_result(logic [1:0] kind, logic [7:0] tag, logic [31:0] len,
                            logic [2:0] hdr, logic [31:0] off, logic [1:0] err, logic last);
    result_t r;
    r.kind = kind;
    r.tag = tag;
    r.length = len;
    r.hdr_bytes = hdr;
    r.offset = off;
    r.error_code = err;
    r.last = last;
    walker_results_due.push_back(r);
  endfunction

  function void walk_fail(logic [1:0] code);
    post_result(KIND_ERR, 8'h00, 32'h0, 3'd0, child_at, code, 1'b1);
    walk_phase = PH_IDLE;
  endfunction

  function void walk_boundary();
    if (bytes_left == 32'h0) begin
      post_result(KIND_DONE, 8'h00, 32'h0, 3'd0, 32'h0, ERR_NONE, 1'b1);
      walk_phase = PH_IDLE;
    end else begin
      walk_phase = PH_TAG;
    end
  endfunction

  function void walk_length_known();
    if (len_accum > bytes_left) begin
      walk_fail(ERR_SHORT);
    end else begin
      post_result(KIND_HDR, tag_held, len_accum, hdr_count, child_at, ERR_NONE, 1'b0);
      if (len_accum == 32'h0) begin
        walk_boundary();
      end else begin
        skip_left = len_accum;
        walk_phase = PH_SKIP;
      end
    end
  endfunction

  function void walk_consume();
    if (bytes_left != 32'h0) bytes_left = bytes_left - 32'd1;
    pos = pos + 32'd1;
  endfunction

  // returns 1 unless the item is a byte that the idle walker drops
  function bit predict_walk(bit act, logic [31:0] rlen, logic [7:0] b);
    logic [6:0] count;
    if (act == ACT_START) begin
      walk_phase = PH_IDLE;
      tag_held = '0;
      len_accum = '0;
      len_left = '0;
      hdr_count = '0;
      pos = '0;
      child_at = '0;
      skip_left = '0;
      bytes_left = rlen;
      walk_boundary();
      return 1'b1;
    end
    case (walk_phase)
      PH_TAG: begin
        child_at = pos;
        tag_held = b;
        hdr_count = 3'd1;
        len_accum = '0;
        len_left = '0;
        if (bytes_left < 32'd2) begin
          walk_consume();
          walk_fail(ERR_SHORT);
        end else begin
          walk_consume();
          walk_phase = PH_LEN0;
        end
      end
      PH_LEN0: begin
        walk_consume();
        hdr_count = 3'd2;
        count = b[6:0] & COUNT_MASK;
        if ((b & LONG_FORM_BIT) == 8'h00) begin
          len_accum = {25'd0, count};
          walk_length_known();
        end else if (count == 7'd0) begin
          walk_fail(ERR_FORM);
        end else if (count > MAX_LEN_BYTES) begin
          walk_fail(ERR_OVF);
        end else if ({25'd0, count} > bytes_left) begin
          walk_fail(ERR_SHORT);
        end else begin
          len_accum = '0;
          len_left = count[2:0];
          walk_phase = PH_LENX;
        end
      end
      PH_LENX: begin
        walk_consume();
        len_accum = {len_accum[23:0], b};
        hdr_count = hdr_count + 3'd1;
        if (len_left != 3'd0) len_left = len_left - 3'd1;
        if (len_left == 3'd0) walk_length_known();
      end
      PH_SKIP: begin
        walk_consume();
        if (skip_left != 32'h0) skip_left = skip_left - 32'd1;
        if (skip_left == 32'h0) walk_boundary();
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(bit act, logic [31:0] rlen, logic [7:0] b, bit typed, result_t want);
    int depth0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_region_length <= rlen;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    depth0 = walker_results_due.size();
    if (predict_walk(act, rlen, b)) items_taken++;
    if (typed) begin
      while (walker_results_due.size() > depth0)
        walker_results_due.delete(walker_results_due.size() - 1);
      walker_results_due.push_back(want);
    end
  endtask

  task automatic send_random_region();
    logic [7:0]  body[$];
    logic [31:0] rlen;
    logic [31:0] vlen;
    logic [31:0] n;
    int k;
    int pick;
    int keep;
    pick = $urandom_range(99);
    if (pick < 75) begin
      // well-formed children with random content
      repeat ($urandom_range(0, 4)) begin
        vlen = ($urandom_range(39) == 0) ? $urandom_range(128, 200) : $urandom_range(0, 6);
        body.push_back(rand_byte());
        if (vlen < 32'd128 && $urandom_range(2) != 0) begin
          body.push_back(vlen[7:0]);
        end else begin
          n = $urandom_range(1, 4);
          body.push_back(LONG_FORM_BIT | n[7:0]);
          for (k = int'(n) - 1; k >= 0; k--) body.push_back(vlen[8*k +: 8]);
        end
        repeat (vlen) body.push_back(rand_byte());
      end
      rlen = body.size();
      case ($urandom_range(9))
        0: if (rlen != 32'h0) rlen = rlen - $urandom_range(1, rlen);
        1: rlen = rlen + $urandom_range(1, 5);
        2: begin
          keep = $urandom_range(body.size());
          while (body.size() > keep) body.delete(body.size() - 1);
        end
        default: ;
      endcase
    end else if (pick < 90) begin
      rlen = $urandom_range(1) ? $urandom : $urandom_range(0, 12);
      repeat ($urandom_range(1, 10)) body.push_back(rand_byte());
    end else begin
      // short region with a long form header and trailing bytes
      rlen = $urandom_range(0, 8);
      body.push_back(rand_byte());
      body.push_back(LONG_FORM_BIT | 8'($urandom_range(0, 7)));
      repeat ($urandom_range(0, 5)) body.push_back(rand_byte());
    end
    send_item(ACT_START, rlen, rand_byte(), 1'b0, NO_RESULT);
    foreach (body[i]) send_item(ACT_DATA, $urandom, body[i], 1'b0, NO_RESULT);
  endtask

  function automatic string show(result_t r);
    return $sformatf("kind %0d tag %02h len %08h hdr %0d off %08h err %0d last %0d",
                     r.kind, r.tag, r.length, r.hdr_bytes, r.offset, r.error_code, r.last);
  endfunction

  function void check_result();
    result_t got;
    result_t want;
    got.kind = out_result_kind;
    got.tag = out_elem_tag;
    got.length = out_elem_length;
    got.hdr_bytes = out_elem_header_len;
    got.offset = out_elem_offset;
    got.error_code = out_error_code;
    got.last = out_last_result;
    if (walker_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", show(got));
    end else begin
      want = walker_results_due.pop_front();
      if (got.kind !== want.kind || got.tag !== want.tag || got.length !== want.length ||
          got.hdr_bytes !== want.hdr_bytes || got.offset !== want.offset ||
          got.error_code !== want.error_code || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %s, got %s", show(want), show(got));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_row(ACT_DATA,  32'h0, 8'h55, 1'b0, NO_RESULT);
    add_row(ACT_START, 32'd10, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h02, 1'b0, NO_RESULT);
    add_row(ACT_START, 32'h0, 8'h00, 1'b1, DONE_RESULT);
    add_row(ACT_START, 32'd5, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h81, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_START, 32'd1, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hAB, 1'b1, error_at(ERR_SHORT, 32'h0));
    add_row(ACT_DATA,  32'h0, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_START, 32'd5, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h01, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h80, 1'b1, error_at(ERR_FORM, 32'h0));
    add_row(ACT_START, 32'd8, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h01, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b1, error_at(ERR_OVF, 32'h0));
    add_row(ACT_START, 32'd3, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h01, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h82, 1'b1, error_at(ERR_SHORT, 32'h0));
    add_row(ACT_START, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h7F, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'h84, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b0, NO_RESULT);
    add_row(ACT_DATA,  32'h0, 8'hFF, 1'b1, error_at(ERR_SHORT, 32'h0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].rlen, directed_rows[i].dbyte,
                directed_rows[i].typed, directed_rows[i].want);
    while (items_taken < 270) send_random_region();

    tx_idle_pct <= 85;
    rx_idle_pct <= 30;
    while (items_taken < 540) send_random_region();

    // no idling, with one long hold-off on the result side
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_go <= 1'b1;
    while (items_taken < 800) send_random_region();

    in_valid <= 1'b0;
    while (walker_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && walker_results_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dtw_pkg.sv
rtl/dtw_front.sv
rtl/dtw_queue.sv
rtl/dtw_back.sv
rtl/der_tlv_sequence_walker_unit.sv
tb/testbench.sv
